FILE: hw/rtl/aesdec_pkg.sv
// aesdec_pkg: shared types, constants and GF(2^8) functions for the AES-128 decryptor
// used by every module of the block; depends on nothing

package aesdec_pkg;

    localparam int unsigned NumRounds = 10;

    typedef logic [127:0] blk_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } plain_t;

    // register indexes
    localparam logic [0:0] RegKeyHigh = 1'b0;
    localparam logic [0:0] RegKeyLow  = 1'b1;

    // byte k of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input blk_t b, input int k);
        get_byte = b[127-8*k -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // forward s-box
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // inverse s-box
    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // round constants for key rounds 1 to 10
    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // one forward key expansion step: key of round r-1 to key of round r
    function automatic blk_t key_step(input blk_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_step = {w0, w1, w2, w3};
    endfunction

    // inverse shift rows plus inverse sub bytes
    function automatic blk_t inv_shift_sub(input blk_t s);
        blk_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*c+r) -: 8] = INV_SBOX[get_byte(s, 4*((c-r)&3)+r)];
            end
        end
        inv_shift_sub = t;
    endfunction

    // inverse mix columns with constant multipliers 0e, 0b, 0d, 09
    function automatic blk_t inv_mix(input blk_t s);
        blk_t t;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = get_byte(s, 4*c+r);
                x2[r] = xtime(a[r]);
                x4[r] = xtime(x2[r]);
                x8[r] = xtime(x4[r]);
                m9[r] = x8[r] ^ a[r];
                mb[r] = x8[r] ^ x2[r] ^ a[r];
                md[r] = x8[r] ^ x4[r] ^ a[r];
                me[r] = x8[r] ^ x4[r] ^ x2[r];
            end
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*c+r) -: 8] = me[r] ^ mb[(r+1)&3] ^ md[(r+2)&3] ^ m9[(r+3)&3];
            end
        end
        inv_mix = t;
    endfunction

endpackage

FILE: hw/rtl/aesdec_cell.sv
// aesdec_cell: one inverse round stage with its own valid bit
// depends on aesdec_pkg

module aesdec_cell
    import aesdec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       in_valid,
    input  blk_t       in_state,
    input  blk_t       in_key,
    input  logic       last,
    output logic       out_valid,
    output blk_t       out_state
);

    logic valid_reg;
    blk_t state_reg;
    blk_t round_next;

    // inverse round: shift, sub, add key, mix unless last round
    always_comb begin
        round_next = inv_shift_sub(in_state) ^ in_key;
        if (!last) begin
            round_next = inv_mix(round_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            state_reg <= round_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

FILE: hw/rtl/aes128_block_decrypt_top.sv
// aes128_block_decrypt_top: pipelined AES-128 block decryptor with APB key port
// depends on aesdec_pkg and aesdec_cell
//
// Usage:
//   s_ channel: ciphertext request (s_valid/s_ready, s_data as cipher_t).
//   m_ channel: plaintext result (m_valid/m_ready, m_data as plain_t).
//   APB port: key_high at 0x0, key_low at 0x8, 64-bit data, pready always high.
//   Write the key only while the pipe is empty; the round keys are expanded
//   once after each write, in a walk that loads the key and then takes one
//   key step per cycle, and the block holds s_ready low until that walk ends.
// Pipeline: one stage for the initial key add plus ten round cells.
// Throughput: one block per cycle unless stalled or in a key walk.
// Stall: when m_ready is low and the output stage is full, the whole row
// holds; nothing is lost. Reset clears all valid bits and the key to zero,
// then runs the key walk before the first request is taken.

module aes128_block_decrypt_top
    import aesdec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  cipher_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output plain_t      m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    // round keys 0..10
    blk_t        rk_reg [NumRounds+1];
    logic [3:0]  exp_cnt_reg;
    logic        exp_busy_reg;

    logic        advance;
    logic        cfg_wr;
    logic        in_acc;
    logic        v0_reg;
    blk_t        s0_reg;
    logic        cv  [NumRounds+1];
    blk_t        cs  [NumRounds+1];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_wr && paddr[2:0] == 3'b000 && paddr[3] == RegKeyHigh) begin
            key_high_reg <= pwdata;
        end else if (cfg_wr && paddr[2:0] == 3'b000 && paddr[3] == RegKeyLow) begin
            key_low_reg  <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2:0] == 3'b000) begin
            prdata = (paddr[3] == RegKeyHigh) ? key_high_reg : key_low_reg;
        end
    end

    // key expansion walk, one round key per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_busy_reg <= 1'b1;
            exp_cnt_reg  <= '0;
        end else if (cfg_wr) begin
            exp_busy_reg <= 1'b1;
            exp_cnt_reg  <= '0;
        end else if (exp_busy_reg) begin
            exp_cnt_reg <= exp_cnt_reg + 4'd1;
            if (exp_cnt_reg == 4'(NumRounds)) begin
                exp_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exp_busy_reg) begin
            if (exp_cnt_reg == 4'd0) begin
                rk_reg[0] <= {key_high_reg, key_low_reg};
            end else begin
                for (int i = 1; i <= NumRounds; i++) begin
                    if (exp_cnt_reg == 4'(i)) begin
                        rk_reg[i] <= key_step(rk_reg[i-1], RCON[i-1]);
                    end
                end
            end
        end
    end

    // pipe moves unless the output stage is full and stalled
    assign advance = !cv[NumRounds] || m_ready;
    assign s_ready = advance && !exp_busy_reg;
    assign in_acc  = s_valid && s_ready;

    // initial add of round key 10
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (advance) begin
            v0_reg <= in_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s0_reg <= {s_data.cipher_high, s_data.cipher_low} ^ rk_reg[NumRounds];
        end
    end

    assign cv[0] = v0_reg;
    assign cs[0] = s0_reg;

    // row of inverse round cells, cell j uses round key 9-j
    for (genvar j = 0; j < NumRounds; j++) begin : g_cell
        aesdec_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (cv[j]),
            .in_state  (cs[j]),
            .in_key    (rk_reg[NumRounds-1-j]),
            .last      (j == NumRounds-1),
            .out_valid (cv[j+1]),
            .out_state (cs[j+1])
        );
    end

    assign m_valid           = cv[NumRounds];
    assign m_data.plain_high = cs[NumRounds][127:64];
    assign m_data.plain_low  = cs[NumRounds][63:0];

endmodule

FILE: tb/aes128_block_decrypt_top_test.sv
// aes128_block_decrypt_top_test: self-checking bench for the AES-128 block decryptor
// depends on aesdec_pkg and aes128_block_decrypt_top; keys go in over APB, plaintext is
// checked against an in-bench inverse cipher built from GF(2^8) arithmetic

module aes128_block_decrypt_top_test;
    import aesdec_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    cipher_t     s_data;
    logic        m_valid;
    logic        m_ready;
    plain_t      m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    aes128_block_decrypt_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // stimulus row: key, ciphertext, and the plaintext where it is known by heart
    typedef struct {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        cipher_t     blk;
        bit          known;
        plain_t      plain;
    } vec_row_t;

    localparam int NumRows = 12;
    localparam int NumPhases = 6;
    localparam int PhaseItems = 255;

    bit [7:0]    sbox_tab [256];
    bit [7:0]    inv_sbox_tab [256];
    bit [7:0]    round_keys [176];
    logic [63:0] cur_key_hi;
    logic [63:0] cur_key_lo;

    plain_t      plain_q [$];
    int          mismatches;
    int          sent_count;
    int          taken_count;
    vec_row_t    vec_rows [NumRows];

    // clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- inverse cipher ----------------

    function automatic bit [7:0] gf_times(bit [7:0] a, bit [7:0] b);
        bit [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    // s-box from the field inverse and the affine map
    function automatic void build_sboxes();
        bit [7:0] inv;
        bit [7:0] y;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int c = 1; c < 256; c++) begin
                if (gf_times(x[7:0], c[7:0]) == 8'h01) inv = c[7:0];
            end
            y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_tab[x] = y;
            inv_sbox_tab[y] = x[7:0];
        end
    endfunction

    // key schedule for the current key, round r at bytes 16r..16r+15
    function automatic void expand_round_keys();
        bit [7:0] t [4];
        bit [7:0] f;
        bit [7:0] rc;
        rc = 8'h01;
        for (int k = 0; k < 8; k++) begin
            round_keys[k]     = cur_key_hi[63-8*k -: 8];
            round_keys[k + 8] = cur_key_lo[63-8*k -: 8];
        end
        for (int i = 4; i < 44; i++) begin
            for (int r = 0; r < 4; r++) t[r] = round_keys[4*(i-1)+r];
            if ((i % 4) == 0) begin
                f = t[0];
                t[0] = sbox_tab[t[1]] ^ rc;
                t[1] = sbox_tab[t[2]];
                t[2] = sbox_tab[t[3]];
                t[3] = sbox_tab[f];
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            for (int r = 0; r < 4; r++) round_keys[4*i+r] = round_keys[4*(i-4)+r] ^ t[r];
        end
    endfunction

    function automatic plain_t decrypt_block(cipher_t c);
        bit [7:0] st [16];
        bit [7:0] t [16];
        bit [127:0] v;
        plain_t res;
        v = c;
        for (int k = 0; k < 16; k++) st[k] = v[127-8*k -: 8] ^ round_keys[160 + k];
        for (int rnd = 9; rnd >= 0; rnd--) begin
            for (int col = 0; col < 4; col++) begin
                for (int r = 0; r < 4; r++) begin
                    t[4*col+r] = inv_sbox_tab[st[4*((col-r)&3)+r]];
                end
            end
            for (int k = 0; k < 16; k++) st[k] = t[k] ^ round_keys[16*rnd + k];
            if (rnd != 0) begin
                for (int col = 0; col < 4; col++) begin
                    for (int r = 0; r < 4; r++) begin
                        t[4*col+r] = gf_times(st[4*col+r], 8'h0e)
                            ^ gf_times(st[4*col+((r+1)&3)], 8'h0b)
                            ^ gf_times(st[4*col+((r+2)&3)], 8'h0d)
                            ^ gf_times(st[4*col+((r+3)&3)], 8'h09);
                    end
                end
                st = t;
            end
        end
        for (int k = 0; k < 16; k++) v[127-8*k -: 8] = st[k];
        res = v;
        return res;
    endfunction

    // ---------------- request and result monitors ----------------

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            plain_q.push_back(decrypt_block(s_data));
            sent_count <= sent_count + 1;
        end
    end

    always @(posedge aclk) begin
        plain_t want;
        if (aresetn && m_valid && m_ready) begin
            taken_count <= taken_count + 1;
            if (plain_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h_%h", m_data.plain_high, m_data.plain_low);
            end else begin
                want = plain_q.pop_front();
                if (m_data.plain_high !== want.plain_high
                        || m_data.plain_low !== want.plain_low) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h_%h got %h_%h", want.plain_high,
                                 want.plain_low, m_data.plain_high, m_data.plain_low);
                end
            end
        end
    end

    // ---------------- result side ready, with one long hold-off ----------------

    always @(posedge aclk) begin
        int hold_left;
        bit held;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
            held = 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!held && sent_count >= 700) begin
            held = 1'b1;
            hold_left = 300;
            m_ready <= 1'b0;
        end else if (taken_count >= 300 && taken_count < 550) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 11);
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_block(cipher_t c);
        while ($urandom_range(99) < 11 && !(sent_count >= 300 && sent_count < 550)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // let every outstanding result drain before touching the key
    task automatic drain();
        s_valid <= 1'b0;
        while (plain_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_key(logic [0:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == RegKeyHigh) cur_key_hi = value;
        else cur_key_lo = value;
        expand_round_keys();
    endtask

    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        drain();
        write_key(RegKeyHigh, hi);
        write_key(RegKeyLow, lo);
    endtask

    function automatic cipher_t random_block();
        cipher_t c;
        c.cipher_high = {$urandom, $urandom};
        c.cipher_low  = {$urandom, $urandom};
        case ($urandom_range(19))
            0: c = '0;
            1: c = '1;
            default: ;
        endcase
        return c;
    endfunction

    function automatic vec_row_t mk_row(logic [63:0] khi, logic [63:0] klo, logic [127:0] c,
                                        bit known, logic [127:0] p);
        vec_row_t row;
        row.key_hi = khi;
        row.key_lo = klo;
        row.blk    = c;
        row.known  = known;
        row.plain  = p;
        return row;
    endfunction

    initial begin
        logic [63:0] khi;
        logic [63:0] klo;
        plain_t want;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        mismatches  = 0;
        sent_count  = 0;
        taken_count = 0;
        cur_key_hi  = '0;
        cur_key_lo  = '0;
        build_sboxes();
        expand_round_keys();

        // directed rows: zero key after reset, the standard vector, extremes
        vec_rows[0]  = mk_row(64'h0, 64'h0, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e,
                              1, 128'h0);
        vec_rows[1]  = mk_row(64'h0, 64'h0, 128'h0, 0, 128'h0);
        vec_rows[2]  = mk_row(64'h0, 64'h0, '1, 0, 128'h0);
        vec_rows[3]  = mk_row(64'h0, 64'h0, {8{16'ha55a}}, 0, 128'h0);
        vec_rows[4]  = mk_row(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                              128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1,
                              128'h00112233445566778899aabbccddeeff);
        vec_rows[5]  = mk_row(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, 0, 128'h0);
        vec_rows[6]  = mk_row('1, '1, 128'h0, 0, 128'h0);
        vec_rows[7]  = mk_row('1, '1, '1, 0, 128'h0);
        vec_rows[8]  = mk_row('1, 64'h0, {8{16'h5aa5}}, 0, 128'h0);
        vec_rows[9]  = mk_row(64'h0, '1, 128'h1, 0, 128'h0);
        vec_rows[10] = mk_row({32{2'b10}}, {32{2'b01}}, 128'h80 << 120, 0, 128'h0);
        vec_rows[11] = mk_row({32{2'b01}}, {32{2'b10}}, {64'h0, {64{1'b1}}}, 0, 128'h0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NumRows; i++) begin
            if (vec_rows[i].key_hi !== cur_key_hi || vec_rows[i].key_lo !== cur_key_lo)
                load_key(vec_rows[i].key_hi, vec_rows[i].key_lo);
            // known rows must agree with the predictor too
            if (vec_rows[i].known) begin
                want = decrypt_block(vec_rows[i].blk);
                if (want !== vec_rows[i].plain) begin
                    mismatches++;
                    $display("vector %0d: expected %h got %h", i, vec_rows[i].plain, want);
                end
            end
            send_block(vec_rows[i].blk);
        end

        // random phases, each under its own key
        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: begin khi = '1; klo = '1; end
                1: begin khi = '0; klo = '0; end
                default: begin khi = {$urandom, $urandom}; klo = {$urandom, $urandom}; end
            endcase
            load_key(khi, klo);
            for (int n = 0; n < PhaseItems; n++) send_block(random_block());
        end
        s_valid <= 1'b0;

        while (plain_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: aes128_block_decrypt_top.f
hw/rtl/aesdec_pkg.sv
hw/rtl/aesdec_cell.sv
hw/rtl/aes128_block_decrypt_top.sv
tb/aes128_block_decrypt_top_test.sv
